>>> rtl/core/pdr_pkg.sv
package pdr_pkg;

    localparam int TARGET_WIDTH = 256;
    localparam int MOD_STEPS    = 32;
    localparam int DEN_W        = 33;
    localparam int TS_W         = 35;
    localparam int MANT_W       = 23;

    localparam logic [16:0] SPACING_RESET  = 17'd600;
    localparam logic [15:0] INTERVAL_RESET = 16'd2016;
    localparam logic [31:0] LIMIT_RESET    = 32'h1d00ffff;

    localparam logic [2:0] REG_SPACING  = 3'd0;
    localparam logic [2:0] REG_INTERVAL = 3'd1;
    localparam logic [2:0] REG_LIMIT    = 3'd2;
    localparam logic [2:0] REG_SMOOTH   = 3'd3;
    localparam logic [2:0] REG_HEIGHT   = 3'd4;

    localparam logic [2:0] PATH_NONE   = 3'd0;
    localparam logic [2:0] PATH_HELD   = 3'd1;
    localparam logic [2:0] PATH_BTC    = 3'd2;
    localparam logic [2:0] PATH_DIGI   = 3'd3;
    localparam logic [2:0] PATH_CAPPED = 3'd4;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_HOLD = 2'd1,
        KIND_BTC  = 2'd2,
        KIND_DIGI = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [31:0]        bits;
        logic [31:0]        mod_n;
        logic [15:0]        mod_rem;
        logic [DEN_W-1:0]   den;
    } meta_t;

    typedef struct packed {
        logic [MANT_W-1:0]  m;
        logic [7:0]         sh;
    } dec_t;

    // compact form to mantissa and left shift, sign bit ignored
    function automatic dec_t decode_compact(input logic [31:0] bits);
        dec_t               d;
        logic [7:0]         size;
        logic [MANT_W-1:0]  mant;
        size = bits[31:24];
        mant = bits[22:0];
        d.sh = 8'd0;
        d.m  = mant;
        if (size == 8'd0) begin
            d.m = '0;
        end else if (size == 8'd1) begin
            d.m = mant >> 16;
        end else if (size == 8'd2) begin
            d.m = mant >> 8;
        end else if (size == 8'd3) begin
            d.m = mant;
        end else if (size >= 8'(3 + TARGET_WIDTH / 8)) begin
            d.m = '0;
        end else begin
            d.sh = {size[4:0] - 5'd3, 3'b000};
        end
        return d;
    endfunction

endpackage

>>> rtl/core/pdr_front.sv
module pdr_front #(
    parameter int W = pdr_pkg::TARGET_WIDTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic                       has_tip,
    input  logic [30:0]                tip_height,
    input  logic [31:0]                tip_bits,
    input  logic [31:0]                tip_time,
    input  logic                       has_parent,
    input  logic [31:0]                parent_time,
    input  logic [31:0]                window_start_time,
    input  logic [16:0]                spacing,
    input  logic [15:0]                interval,
    input  logic [pdr_pkg::DEN_W-1:0]  span,
    input  logic                       smooth_enable,
    input  logic [30:0]                smooth_height,
    output logic                       out_valid,
    output pdr_pkg::meta_t             out_meta,
    output logic [W-1:0]               out_word
);

    // stage 1: raw differences and mode
    logic               s1_valid_reg;
    logic               s1_tip_reg, s1_parent_reg, s1_smooth_reg;
    logic [31:0]        s1_bits_reg, s1_n_reg;
    logic [32:0]        s1_act_s_reg, s1_act_b_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s1_tip_reg    <= has_tip;
            s1_parent_reg <= has_parent;
            s1_smooth_reg <= smooth_enable && (tip_height >= smooth_height);
            s1_bits_reg   <= tip_bits;
            s1_n_reg      <= {1'b0, tip_height} + 32'd1;
            s1_act_s_reg  <= {1'b0, tip_time} - {1'b0, parent_time};
            s1_act_b_reg  <= {1'b0, tip_time} - {1'b0, window_start_time};
        end
    end

    // stage 2: timespan, divisor, decoded target
    logic signed [34:0] ds_diff, ds_q, ds_ts, ds_lo, ds_hi, ds_cl;
    logic [18:0]        tgt3;
    logic signed [35:0] bt_act, bt_lo, bt_hi, bt_cl;
    pdr_pkg::meta_t     s2_meta_next;
    logic [pdr_pkg::TS_W-1:0] s2_ts_next;
    pdr_pkg::dec_t      s2_dec_next;

    always_comb begin
        ds_diff = $signed({{2{s1_act_s_reg[32]}}, s1_act_s_reg}) - $signed({18'd0, spacing});
        ds_q    = ds_diff[34] ? ((ds_diff + 35'sd7) >>> 3) : (ds_diff >>> 3);
        ds_ts   = $signed({18'd0, spacing}) + ds_q;
        tgt3    = {2'b00, spacing} + {1'b0, spacing, 1'b0};
        ds_lo   = $signed({18'd0, tgt3[18:2]});
        ds_hi   = $signed({17'd0, tgt3[18:1]});
        ds_cl   = ds_ts;
        if (ds_cl < ds_lo) ds_cl = ds_lo;
        if (ds_cl > ds_hi) ds_cl = ds_hi;

        bt_act = $signed({{3{s1_act_b_reg[32]}}, s1_act_b_reg});
        bt_lo  = $signed({5'd0, span[32:2]});
        bt_hi  = $signed({1'b0, span, 2'b00});
        bt_cl  = bt_act;
        if (bt_cl < bt_lo) bt_cl = bt_lo;
        if (bt_cl > bt_hi) bt_cl = bt_hi;

        s2_meta_next.bits    = s1_bits_reg;
        s2_meta_next.mod_n   = s1_n_reg;
        s2_meta_next.mod_rem = '0;
        s2_meta_next.den     = span;
        s2_ts_next           = bt_cl[34:0];
        if (!s1_tip_reg) begin
            s2_meta_next.kind = pdr_pkg::KIND_NONE;
        end else if (s1_smooth_reg) begin
            s2_meta_next.den = {16'd0, spacing};
            s2_ts_next       = ds_cl;
            s2_meta_next.kind = (s1_parent_reg && spacing != '0) ? pdr_pkg::KIND_DIGI
                                                                  : pdr_pkg::KIND_HOLD;
        end else begin
            s2_meta_next.kind = (interval != '0 && span != '0) ? pdr_pkg::KIND_BTC
                                                                : pdr_pkg::KIND_HOLD;
        end
        s2_dec_next = pdr_pkg::decode_compact(s1_bits_reg);
    end

    logic                       s2_valid_reg, s3_valid_reg, s4_valid_reg;
    pdr_pkg::meta_t             s2_meta_reg, s3_meta_reg, s4_meta_reg;
    logic [pdr_pkg::TS_W-1:0]   s2_ts_reg;
    pdr_pkg::dec_t              s2_dec_reg;
    logic [pdr_pkg::TS_W+pdr_pkg::MANT_W-1:0] s3_prod_reg;
    logic [7:0]                 s3_sh_reg;
    logic [W-1:0]               s4_word_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s2_meta_reg <= s2_meta_next;
            s2_ts_reg   <= s2_ts_next;
            s2_dec_reg  <= s2_dec_next;
            // stage 3: mantissa times timespan
            s3_meta_reg <= s2_meta_reg;
            s3_prod_reg <= {{pdr_pkg::TS_W{1'b0}}, s2_dec_reg.m} *
                           {{pdr_pkg::MANT_W{1'b0}}, s2_ts_reg};
            s3_sh_reg   <= s2_dec_reg.sh;
            // stage 4: place product in the target word, bits past the top drop
            s4_meta_reg <= s3_meta_reg;
            s4_word_reg <= W'(s3_prod_reg) << s3_sh_reg;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_meta  = s4_meta_reg;
    assign out_word  = s4_word_reg;

endmodule

>>> rtl/core/pdr_div_cell.sv
module pdr_div_cell #(
    parameter int W   = pdr_pkg::TARGET_WIDTH,
    parameter int IDX = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic [15:0]                interval,
    input  logic                       in_valid,
    input  pdr_pkg::meta_t             in_meta,
    input  logic [W-1:0]               in_word,
    input  logic [pdr_pkg::DEN_W-1:0]  in_rem,
    output logic                       out_valid,
    output pdr_pkg::meta_t             out_meta,
    output logic [W-1:0]               out_word,
    output logic [pdr_pkg::DEN_W-1:0]  out_rem
);

    logic [pdr_pkg::DEN_W:0]    cur;
    logic                       ge;
    logic [pdr_pkg::DEN_W-1:0]  rem_next;
    logic [W-1:0]               word_next;
    pdr_pkg::meta_t             meta_next;

    // one restoring division step: quotient bit shifts in at the bottom
    always_comb begin
        cur       = {in_rem, in_word[W-1]};
        ge        = cur >= {1'b0, in_meta.den};
        rem_next  = ge ? pdr_pkg::DEN_W'(cur - {1'b0, in_meta.den}) : cur[pdr_pkg::DEN_W-1:0];
        word_next = {in_word[W-2:0], ge};
    end

    // first cells also reduce next height modulo the interval
    generate
        if (IDX < pdr_pkg::MOD_STEPS) begin : g_mod
            logic [16:0] mcur;
            always_comb begin
                meta_next       = in_meta;
                mcur            = {in_meta.mod_rem, in_meta.mod_n[31]};
                meta_next.mod_n = {in_meta.mod_n[30:0], 1'b0};
                if (mcur >= {1'b0, interval}) begin
                    meta_next.mod_rem = 16'(mcur - {1'b0, interval});
                end else begin
                    meta_next.mod_rem = mcur[15:0];
                end
            end
        end else begin : g_pass
            always_comb begin
                meta_next = in_meta;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            out_meta <= meta_next;
            out_word <= word_next;
            out_rem  <= rem_next;
        end
    end

endmodule

>>> rtl/core/pdr_back.sv
module pdr_back #(
    parameter int W = pdr_pkg::TARGET_WIDTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic [31:0]     limit_bits,
    input  logic            in_valid,
    input  pdr_pkg::meta_t  in_meta,
    input  logic [W-1:0]    in_quot,
    output logic            out_valid,
    output logic [31:0]     out_bits,
    output logic [2:0]      out_path
);

    localparam int NC = W / 32;
    localparam int LW = $clog2(W + 1);

    pdr_pkg::dec_t  lim_dec;
    logic [W-1:0]   lim_w;
    logic           capped, retgt;
    logic [2:0]     path_b1;
    logic [31:0]    bits_b1;

    // stage 1: cap at the limit and pick the path
    always_comb begin
        lim_dec = pdr_pkg::decode_compact(limit_bits);
        lim_w   = W'(lim_dec.m) << lim_dec.sh;
        capped  = in_quot > lim_w;
        retgt   = (in_meta.kind == pdr_pkg::KIND_DIGI) ||
                  (in_meta.kind == pdr_pkg::KIND_BTC && in_meta.mod_rem == '0);
        bits_b1 = in_meta.bits;
        if (in_meta.kind == pdr_pkg::KIND_NONE) begin
            path_b1 = pdr_pkg::PATH_NONE;
            bits_b1 = limit_bits;
        end else if (!retgt) begin
            path_b1 = pdr_pkg::PATH_HELD;
        end else if (capped) begin
            path_b1 = pdr_pkg::PATH_CAPPED;
        end else if (in_meta.kind == pdr_pkg::KIND_DIGI) begin
            path_b1 = pdr_pkg::PATH_DIGI;
        end else begin
            path_b1 = pdr_pkg::PATH_BTC;
        end
    end

    logic           b1_valid_reg, b2_valid_reg, b3_valid_reg;
    logic [W-1:0]   b1_val_reg, b2_val_reg, b3_val_reg;
    logic           b1_ret_reg, b2_ret_reg, b3_ret_reg;
    logic [2:0]     b1_path_reg, b2_path_reg, b3_path_reg;
    logic [31:0]    b1_bits_reg, b2_bits_reg, b3_bits_reg;
    logic [NC-1:0]  b2_nz_reg;
    logic [4:0]     b2_pos_reg [NC];
    logic [7:0]     b3_size_reg;

    logic [NC-1:0]  nz_next;
    logic [4:0]     pos_next [NC];
    logic [LW-1:0]  bitlen;

    // stage 2: leading one inside each 32-bit chunk
    always_comb begin
        for (int c = 0; c < NC; c++) begin
            nz_next[c]  = b1_val_reg[c*32 +: 32] != '0;
            pos_next[c] = '0;
            for (int b = 0; b < 32; b++) begin
                if (b1_val_reg[c*32 + b]) pos_next[c] = 5'(b);
            end
        end
    end

    // stage 3: highest nonzero chunk gives the bit length
    always_comb begin
        bitlen = '0;
        for (int c = 0; c < NC; c++) begin
            if (b2_nz_reg[c]) bitlen = LW'(c * 32) + LW'(b2_pos_reg[c]) + LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
        end else if (en) begin
            b1_valid_reg <= in_valid;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            b1_val_reg  <= capped ? lim_w : in_quot;
            b1_ret_reg  <= retgt;
            b1_path_reg <= path_b1;
            b1_bits_reg <= bits_b1;
            b2_val_reg  <= b1_val_reg;
            b2_ret_reg  <= b1_ret_reg;
            b2_path_reg <= b1_path_reg;
            b2_bits_reg <= b1_bits_reg;
            b2_nz_reg   <= nz_next;
            for (int c = 0; c < NC; c++) b2_pos_reg[c] <= pos_next[c];
            b3_val_reg  <= b2_val_reg;
            b3_ret_reg  <= b2_ret_reg;
            b3_path_reg <= b2_path_reg;
            b3_bits_reg <= b2_bits_reg;
            b3_size_reg <= 8'((bitlen + LW'(7)) >> 3);
        end
    end

    // stage 4: pull out the mantissa and re-encode
    logic [31:0]    c32;
    logic [23:0]    c24;
    logic [7:0]     size;
    logic [10:0]    sh_b;

    always_comb begin
        sh_b = {b3_size_reg - 8'd3, 3'b000};
        case (b3_size_reg)
            8'd0:    c32 = '0;
            8'd1:    c32 = b3_val_reg[31:0] << 16;
            8'd2:    c32 = b3_val_reg[31:0] << 8;
            8'd3:    c32 = b3_val_reg[31:0];
            default: c32 = 32'(b3_val_reg >> sh_b);
        endcase
        c24  = c32[23:0];
        size = b3_size_reg;
        if (c24[23]) begin
            c24  = c24 >> 8;
            size = size + 8'd1;
        end
        out_bits = b3_ret_reg ? {size, c24} : b3_bits_reg;
    end

    assign out_valid = b3_valid_reg;
    assign out_path  = b3_path_reg;

endmodule

>>> rtl/core/pow_difficulty_retarget.sv
// throughput: one item per cycle while not stalled, through the 256-cell restoring divider chain
// stalls freeze the whole pipeline; an output skid stage keeps one item of slack
// reset: rst_n asynchronous active low, clears valid bits and restores register defaults
module pow_difficulty_retarget #(
    parameter int TARGET_WIDTH = pdr_pkg::TARGET_WIDTH
) (
    input  logic         clk,
    input  logic         rst_n,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,   // tip_height, tip_bits, tip_time, parent_time,
                                    // window_start_time, zero pad
    input  logic [1:0]   s_tuser,   // has_tip, has_parent
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // next_bits
    output logic [2:0]   m_tuser,   // path_taken
    // register writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int W = TARGET_WIDTH;
    localparam int NCELL = TARGET_WIDTH;

    // configuration registers
    logic [16:0] spacing_reg;
    logic [15:0] interval_reg;
    logic [31:0] limit_reg;
    logic        smooth_en_reg;
    logic [30:0] smooth_height_reg;
    logic [pdr_pkg::DEN_W-1:0] span_reg;   // spacing * interval, follows the registers

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            spacing_reg       <= pdr_pkg::SPACING_RESET;
            interval_reg      <= pdr_pkg::INTERVAL_RESET;
            limit_reg         <= pdr_pkg::LIMIT_RESET;
            smooth_en_reg     <= 1'b0;
            smooth_height_reg <= '0;
            span_reg          <= '0;
        end else begin
            span_reg <= {16'd0, spacing_reg} * {17'd0, interval_reg};
            if (cfg_valid) begin
                unique case (cfg_index)
                    pdr_pkg::REG_SPACING:  spacing_reg       <= cfg_data[16:0];
                    pdr_pkg::REG_INTERVAL: interval_reg      <= cfg_data[15:0];
                    pdr_pkg::REG_LIMIT:    limit_reg         <= cfg_data;
                    pdr_pkg::REG_SMOOTH:   smooth_en_reg     <= cfg_data[0];
                    pdr_pkg::REG_HEIGHT:   smooth_height_reg <= cfg_data[30:0];
                    default: ;  // unknown index, write dropped
                endcase
            end
        end
    end

    // whole pipe moves together unless the skid stage is holding an item
    logic skid_valid_reg;
    logic en;
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // front: timespan, product, shifted target
    logic                 f_valid;
    pdr_pkg::meta_t       f_meta;
    logic [W-1:0]         f_word;

    pdr_front #(.W(W)) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .en                (en),
        .in_valid          (s_tvalid && s_tready),
        .has_tip           (s_tuser[0]),
        .tip_height        (s_tdata[30:0]),
        .tip_bits          (s_tdata[62:31]),
        .tip_time          (s_tdata[94:63]),
        .has_parent        (s_tuser[1]),
        .parent_time       (s_tdata[126:95]),
        .window_start_time (s_tdata[158:127]),
        .spacing           (spacing_reg),
        .interval          (interval_reg),
        .span              (span_reg),
        .smooth_enable     (smooth_en_reg),
        .smooth_height     (smooth_height_reg),
        .out_valid         (f_valid),
        .out_meta          (f_meta),
        .out_word          (f_word)
    );

    // divider chain, one quotient bit per cell
    logic                      c_valid [NCELL+1];
    pdr_pkg::meta_t            c_meta  [NCELL+1];
    logic [W-1:0]              c_word  [NCELL+1];
    logic [pdr_pkg::DEN_W-1:0] c_rem   [NCELL+1];

    assign c_valid[0] = f_valid;
    assign c_meta[0]  = f_meta;
    assign c_word[0]  = f_word;
    assign c_rem[0]   = '0;

    generate
        for (genvar i = 0; i < NCELL; i++) begin : g_cell
            pdr_div_cell #(.W(W), .IDX(i)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .interval  (interval_reg),
                .in_valid  (c_valid[i]),
                .in_meta   (c_meta[i]),
                .in_word   (c_word[i]),
                .in_rem    (c_rem[i]),
                .out_valid (c_valid[i+1]),
                .out_meta  (c_meta[i+1]),
                .out_word  (c_word[i+1]),
                .out_rem   (c_rem[i+1])
            );
        end
    endgenerate

    // back: cap, bit length, compact encoding
    logic        b_valid;
    logic [31:0] b_bits;
    logic [2:0]  b_path;

    pdr_back #(.W(W)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .limit_bits (limit_reg),
        .in_valid   (c_valid[NCELL]),
        .in_meta    (c_meta[NCELL]),
        .in_quot    (c_word[NCELL]),
        .out_valid  (b_valid),
        .out_bits   (b_bits),
        .out_path   (b_path)
    );

    // output register plus skid stage
    logic        out_valid_reg;
    logic [31:0] out_bits_reg, skid_bits_reg;
    logic [2:0]  out_path_reg, skid_path_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= b_valid;
        end else if (b_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_bits_reg <= skid_bits_reg;
                out_path_reg <= skid_path_reg;
            end
        end else if (!out_valid_reg || m_tready) begin
            out_bits_reg <= b_bits;
            out_path_reg <= b_path;
        end else begin
            skid_bits_reg <= b_bits;
            skid_path_reg <= b_path;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_bits_reg;
    assign m_tuser  = out_path_reg;

`ifndef NO_ASSERTIONS
    // skid only fills behind a waiting output item
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> m_tvalid)
        else $error("skid holds an item while output is empty");

    // path codes stay within the defined set
    a_path_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= pdr_pkg::PATH_CAPPED))
        else $error("undefined path code");

    // no-tip results carry the limit unchanged
    a_no_tip_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == pdr_pkg::PATH_NONE) |-> (m_tdata == limit_reg))
        else $error("no-tip result differs from limit");
`endif

endmodule
